>>> hdl/ccpp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccpp_pkg
// Shared types and constants for the clear color to packed pixel core.
// ----------------------------------------------------------------------------
package ccpp_pkg;

    localparam int unsigned WordWidth  = 32;
    localparam int unsigned ByteWidth  = 8;
    localparam int unsigned Lanes      = 4;
    localparam int unsigned SigWidth   = 24;
    localparam int unsigned ProdWidth  = SigWidth + ByteWidth;
    localparam int unsigned ShiftWidth = 6;

    localparam logic [7:0] OneExp     = 8'd127;
    localparam logic [7:0] LowExp     = 8'd111;   // 127 - 16
    localparam logic [7:0] ShiftBase  = 8'd149;   // 22 + 127
    localparam logic [7:0] FullScale  = 8'd255;
    localparam logic [7:0] ByteZero   = 8'd0;

    // what a lane found for its channel
    typedef enum logic [1:0] {
        CH_ZERO,
        CH_FULL,
        CH_FRAC
    } ccpp_kind_t;

    typedef struct packed {
        logic depth_clear;
        logic blue_first_order;
    } ccpp_ctrl_t;

endpackage : ccpp_pkg
`default_nettype wire

>>> hdl/ccpp_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccpp_lane
// One channel: float32 bits to a rounded, clamped unorm8 byte, one register
// stage after the significand multiply.
// ----------------------------------------------------------------------------
module ccpp_lane (
    input  wire logic                                clk,
    input  wire logic                                load,
    input  wire logic [ccpp_pkg::WordWidth-1:0]      word,
    output logic      [ccpp_pkg::ByteWidth-1:0]      chan_byte
);

    logic [7:0]                          expo;
    logic [7:0]                          shift_wide;
    ccpp_pkg::ccpp_kind_t                kind_next;
    ccpp_pkg::ccpp_kind_t                kind_reg;
    logic [ccpp_pkg::ProdWidth-1:0]      prod_next;
    logic [ccpp_pkg::ProdWidth-1:0]      prod_reg;
    logic [ccpp_pkg::ShiftWidth-1:0]     shift_next;
    logic [ccpp_pkg::ShiftWidth-1:0]     shift_reg;
    logic [ccpp_pkg::ProdWidth-1:0]      scaled;
    logic [9:0]                          rounded;

    assign expo = word[30:23];

    always_comb
    begin
        if (word[31])
        begin
            kind_next = ccpp_pkg::CH_ZERO;
        end
        else if (expo >= ccpp_pkg::OneExp)
        begin
            kind_next = ccpp_pkg::CH_FULL;
        end
        else if (expo < ccpp_pkg::LowExp)
        begin
            kind_next = ccpp_pkg::CH_ZERO;
        end
        else
        begin
            kind_next = ccpp_pkg::CH_FRAC;
        end
    end

    // sig * 255, then shift by one less than the full scale shift
    assign prod_next  = {1'b1, word[22:0]} * ccpp_pkg::FullScale;
    assign shift_wide = ccpp_pkg::ShiftBase - expo;
    assign shift_next = shift_wide[ccpp_pkg::ShiftWidth-1:0];

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg  <= kind_next;
            prod_reg  <= prod_next;
            shift_reg <= shift_next;
        end
    end

    // round half up: add one at the last kept bit, then drop it
    assign scaled  = prod_reg >> shift_reg;
    assign rounded = {1'b0, scaled[8:0]} + 10'd1;

    always_comb
    begin
        case (kind_reg)
            ccpp_pkg::CH_FULL: chan_byte = ccpp_pkg::FullScale;
            ccpp_pkg::CH_FRAC: chan_byte = rounded[8:1];
            default:           chan_byte = ccpp_pkg::ByteZero;
        endcase
    end

endmodule : ccpp_lane
`default_nettype wire

>>> hdl/ccpp_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccpp_merge
// Packs the four lane bytes in RGBA or BGRA order, or passes the depth word,
// into the output register.
// ----------------------------------------------------------------------------
module ccpp_merge (
    input  wire logic                                clk,
    input  wire logic                                load,
    input  wire ccpp_pkg::ccpp_ctrl_t                ctrl,
    input  wire logic [ccpp_pkg::WordWidth-1:0]      depth_word,
    input  wire logic [ccpp_pkg::ByteWidth-1:0]      red_byte,
    input  wire logic [ccpp_pkg::ByteWidth-1:0]      green_byte,
    input  wire logic [ccpp_pkg::ByteWidth-1:0]      blue_byte,
    input  wire logic [ccpp_pkg::ByteWidth-1:0]      alpha_byte,
    output logic      [ccpp_pkg::WordWidth-1:0]      pixel_value
);

    logic [ccpp_pkg::WordWidth-1:0] pixel_next;
    logic [ccpp_pkg::WordWidth-1:0] pixel_reg;

    always_comb
    begin
        if (ctrl.depth_clear)
        begin
            pixel_next = depth_word;
        end
        else if (ctrl.blue_first_order)
        begin
            pixel_next = {alpha_byte, red_byte, green_byte, blue_byte};
        end
        else
        begin
            pixel_next = {alpha_byte, blue_byte, green_byte, red_byte};
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pixel_reg <= pixel_next;
        end
    end

    assign pixel_value = pixel_reg;

endmodule : ccpp_merge
`default_nettype wire

>>> hdl/clear_color_to_packed_pixel_core.sv
// An accepted item is held in the first stage register and moves on into the
// output register once that is free, where it waits to be taken. One item is
// accepted every cycle while the output is taken. Four channel lanes multiply
// the significand by 255 into the first stage register. The second stage
// rounds, clamps and packs the bytes (or passes the depth word) into the
// output register. A stall on the output side backs up through both stages.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clear_color_to_packed_pixel_core
// Converts one clear value (four float32 channels) to a packed 32-bit fill
// word, or passes the depth word through.
// ----------------------------------------------------------------------------
module clear_color_to_packed_pixel_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // red_word, green_word, blue_word, alpha_word
    input  wire logic [127:0] s_tdata,
    // depth_clear, blue_first_order
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // pixel_value
    output logic      [31:0]  m_tdata
);

    localparam int unsigned W = ccpp_pkg::WordWidth;

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  out_free;
    logic                  s1_move;
    logic                  in_take;
    ccpp_pkg::ccpp_ctrl_t  ctrl_reg;
    logic [W-1:0]          depth_reg;
    logic [ccpp_pkg::ByteWidth-1:0] lane_byte [ccpp_pkg::Lanes];

    assign out_free = !out_valid_reg || m_tready;
    assign s1_move  = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign in_take  = s_tvalid && s_tready;

    assign s1_valid_next  = in_take || (s1_valid_reg && !out_free);
    assign out_valid_next = s1_move || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            ctrl_reg.depth_clear      <= s_tuser[0];
            ctrl_reg.blue_first_order <= s_tuser[1];
            depth_reg                 <= s_tdata[W-1:0];
        end
    end

    genvar i;
    generate
        for (i = 0; i < ccpp_pkg::Lanes; i++)
        begin : g_lane
            ccpp_lane u_lane (
                .clk       (clk),
                .load      (in_take),
                .word      (s_tdata[i*W +: W]),
                .chan_byte (lane_byte[i])
            );
        end
    endgenerate

    ccpp_merge u_merge (
        .clk         (clk),
        .load        (s1_move),
        .ctrl        (ctrl_reg),
        .depth_word  (depth_reg),
        .red_byte    (lane_byte[0]),
        .green_byte  (lane_byte[1]),
        .blue_byte   (lane_byte[2]),
        .alpha_byte  (lane_byte[3]),
        .pixel_value (m_tdata)
    );

    assign m_tvalid = out_valid_reg;

    // a free output stage never blocks the input
    a_ready_when_free : assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output stage free");

    // a result appears only after the first stage held an item
    a_out_from_stage1 : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s1_valid_reg))
        else $error("output valid without a first stage item");

    // an item that moves forward must show on the output next cycle
    a_move_lands : assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |=> m_tvalid)
        else $error("item lost between stages");

endmodule : clear_color_to_packed_pixel_core
`default_nettype wire
